### rtl/core/tked_pkg.sv
// tked_pkg: types, constants and lookup functions for the terminal key escape decoder.
// Used by tked_decode, tked_out_queue and terminal_key_escape_decoder_unit.
`timescale 1ns / 1ps

package tked_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 11;
    localparam int TDATA_W = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_CSI  = 3'd2,
        PH_SS3  = 3'd3,
        PH_DIG  = 3'd4,
        PH_FKEY = 3'd5,
        PH_MOD1 = 3'd6,
        PH_MOD2 = 3'd7
    } phase_t;

    localparam byte_t CH_ESC   = 8'd27;
    localparam byte_t CH_LBRK  = 8'h5B;
    localparam byte_t CH_O     = 8'h4F;
    localparam byte_t CH_TILDE = 8'h7E;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_1     = 8'h31;
    localparam byte_t CH_2     = 8'h32;
    localparam byte_t CH_3     = 8'h33;
    localparam byte_t CH_4     = 8'h34;
    localparam byte_t CH_5     = 8'h35;
    localparam byte_t CH_6     = 8'h36;
    localparam byte_t CH_7     = 8'h37;
    localparam byte_t CH_8     = 8'h38;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_A     = 8'h41;
    localparam byte_t CH_B     = 8'h42;
    localparam byte_t CH_C     = 8'h43;
    localparam byte_t CH_D     = 8'h44;
    localparam byte_t CH_F     = 8'h46;
    localparam byte_t CH_H     = 8'h48;
    localparam byte_t CH_P     = 8'h50;
    localparam byte_t CH_Q     = 8'h51;
    localparam byte_t CH_R     = 8'h52;
    localparam byte_t CH_S     = 8'h53;

    localparam code_t KC_ESC       = 11'd27;
    localparam code_t KC_UP        = 11'd1000;
    localparam code_t KC_DOWN      = 11'd1001;
    localparam code_t KC_LEFT      = 11'd1002;
    localparam code_t KC_RIGHT     = 11'd1003;
    localparam code_t KC_HOME      = 11'd1004;
    localparam code_t KC_END       = 11'd1005;
    localparam code_t KC_PGUP      = 11'd1006;
    localparam code_t KC_PGDN      = 11'd1007;
    localparam code_t KC_INS       = 11'd1008;
    localparam code_t KC_DEL       = 11'd1009;
    localparam code_t KC_F1        = 11'd1011;
    localparam code_t KC_F2        = 11'd1012;
    localparam code_t KC_F3        = 11'd1013;
    localparam code_t KC_F4        = 11'd1014;
    localparam code_t KC_F10       = 11'd1020;
    localparam code_t KC_SH_UP     = 11'd1100;
    localparam code_t KC_SH_DOWN   = 11'd1101;
    localparam code_t KC_SH_LEFT   = 11'd1102;
    localparam code_t KC_SH_RIGHT  = 11'd1103;
    localparam code_t KC_CTRL_INS  = 11'd1104;
    localparam code_t KC_SH_DEL    = 11'd1105;
    localparam code_t KC_SH_INS    = 11'd1106;

    typedef struct packed {
        code_t code;
        logic  last;
    } qword_t;

    // results of one decoded byte: num is 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        qword_t     w0;
        qword_t     w1;
    } dec_res_t;

    function automatic logic is_digit(input byte_t b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic code_t csi_letter(input byte_t b);
        code_t c;
        unique case (b)
            CH_A:    c = KC_UP;
            CH_B:    c = KC_DOWN;
            CH_C:    c = KC_RIGHT;
            CH_D:    c = KC_LEFT;
            CH_H:    c = KC_HOME;
            CH_F:    c = KC_END;
            default: c = KC_ESC;
        endcase
        return c;
    endfunction

    function automatic code_t ss3_letter(input byte_t b);
        code_t c;
        unique case (b)
            CH_H:    c = KC_HOME;
            CH_F:    c = KC_END;
            CH_P:    c = KC_F1;
            CH_Q:    c = KC_F2;
            CH_R:    c = KC_F3;
            CH_S:    c = KC_F4;
            default: c = KC_ESC;
        endcase
        return c;
    endfunction

    function automatic code_t digit_tilde(input byte_t d);
        code_t c;
        unique case (d)
            CH_1:    c = KC_HOME;
            CH_2:    c = KC_INS;
            CH_3:    c = KC_DEL;
            CH_4:    c = KC_END;
            CH_5:    c = KC_PGUP;
            CH_6:    c = KC_PGDN;
            CH_7:    c = KC_HOME;
            CH_8:    c = KC_END;
            default: c = KC_ESC;
        endcase
        return c;
    endfunction

    function automatic code_t modifier_key(input byte_t d, input byte_t m, input byte_t f);
        code_t c;
        c = KC_ESC;
        priority if (d == CH_1 && m == CH_2 && f == CH_A) c = KC_SH_UP;
        else if (d == CH_1 && m == CH_2 && f == CH_B)     c = KC_SH_DOWN;
        else if (d == CH_1 && m == CH_2 && f == CH_C)     c = KC_SH_RIGHT;
        else if (d == CH_1 && m == CH_2 && f == CH_D)     c = KC_SH_LEFT;
        else if (f == CH_TILDE && d == CH_2 && m == CH_5) c = KC_CTRL_INS;
        else if (f == CH_TILDE && d == CH_3 && m == CH_2) c = KC_SH_DEL;
        else if (f == CH_TILDE && d == CH_2 && m == CH_2) c = KC_SH_INS;
        else                                              c = KC_ESC;
        return c;
    endfunction

    function automatic logic fkey_mid(input byte_t d, input byte_t n);
        return (d == CH_1 && n >= CH_1 && n <= CH_5) || (d == CH_2 && n == CH_1);
    endfunction

    function automatic code_t fkey_code(input byte_t d, input byte_t n, input byte_t f);
        code_t c;
        byte_t off;
        off = n - CH_1;
        priority if (f != CH_TILDE)                c = KC_ESC;
        else if (d == CH_1 && n >= CH_1 && n <= CH_5) c = KC_F1 + code_t'(off);
        else if (d == CH_2 && n == CH_1)           c = KC_F10;
        else                                       c = KC_ESC;
        return c;
    endfunction

endpackage

### rtl/core/tked_decode.sv
// tked_decode: input word register, sequence state and single-pass key decode.
// Depends on tked_pkg.
`timescale 1ns / 1ps

module tked_decode
    import tked_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  byte_t    in_byte,
    input  logic     space_ok,
    output dec_res_t res
);

    logic   in_valid_reg;
    byte_t  in_byte_reg;
    phase_t phase_reg, phase_next;
    byte_t  lead_digit_reg, lead_digit_next;
    byte_t  mid_byte_reg, mid_byte_next;
    logic   fire;
    byte_t  b;

    assign b        = in_byte_reg;
    assign fire     = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            lead_digit_reg <= '0;
            mid_byte_reg   <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            lead_digit_reg <= lead_digit_next;
            mid_byte_reg   <= mid_byte_next;
        end
    end

    // next state
    always_comb begin
        phase_next      = PH_IDLE;
        lead_digit_next = lead_digit_reg;
        mid_byte_next   = mid_byte_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                phase_next = (b == CH_ESC) ? PH_ESC : PH_IDLE;
            end
            PH_ESC: begin
                priority if (b == CH_LBRK) phase_next = PH_CSI;
                else if (b == CH_O)        phase_next = PH_SS3;
                else                       phase_next = PH_IDLE;
            end
            PH_CSI: begin
                if (is_digit(b)) begin
                    phase_next      = PH_DIG;
                    lead_digit_next = b;
                end
            end
            PH_SS3: phase_next = PH_IDLE;
            PH_DIG: begin
                priority if (b == CH_TILDE) begin
                    phase_next = PH_IDLE;
                end else if (b == CH_SEMI) begin
                    phase_next = PH_MOD1;
                end else if (fkey_mid(lead_digit_reg, b)) begin
                    phase_next    = PH_FKEY;
                    mid_byte_next = b;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_FKEY: phase_next = PH_IDLE;
            PH_MOD1: begin
                phase_next    = PH_MOD2;
                mid_byte_next = b;
            end
            PH_MOD2: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // result words
    always_comb begin
        res         = '0;
        res.w0.last = 1'b1;
        res.w1.last = 1'b1;
        res.w0.code = KC_ESC;
        res.w1.code = code_t'(b);
        unique case (phase_reg)
            PH_IDLE: begin
                if (b != CH_ESC) begin
                    res.num     = 2'd1;
                    res.w0.code = code_t'(b);
                end
            end
            PH_ESC: begin
                priority if (b == CH_LBRK || b == CH_O) begin
                    res.num = 2'd0;
                end else if (b == CH_ESC) begin
                    res.num = 2'd1;
                end else begin
                    res.num     = 2'd2;
                    res.w0.last = 1'b0;
                end
            end
            PH_CSI: begin
                if (!is_digit(b)) begin
                    res.num     = 2'd1;
                    res.w0.code = csi_letter(b);
                end
            end
            PH_SS3: begin
                res.num     = 2'd1;
                res.w0.code = ss3_letter(b);
            end
            PH_DIG: begin
                priority if (b == CH_TILDE) begin
                    res.num     = 2'd1;
                    res.w0.code = digit_tilde(lead_digit_reg);
                end else if (b == CH_SEMI || fkey_mid(lead_digit_reg, b)) begin
                    res.num = 2'd0;
                end else begin
                    res.num = 2'd1;
                end
            end
            PH_FKEY: begin
                res.num     = 2'd1;
                res.w0.code = fkey_code(lead_digit_reg, mid_byte_reg, b);
            end
            PH_MOD1: res.num = 2'd0;
            PH_MOD2: begin
                res.num     = 2'd1;
                res.w0.code = modifier_key(lead_digit_reg, mid_byte_reg, b);
            end
            default: res.num = 2'd0;
        endcase
        if (!fire) begin
            res.num = 2'd0;
        end
    end

    a_two_only_from_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        res.num == 2'd2 |-> phase_reg == PH_ESC && phase_next == PH_IDLE)
        else $error("two results outside the ESC phase");

    a_mod_holds_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == PH_MOD1 |=> mid_byte_reg == $past(in_byte_reg))
        else $error("modifier digit not captured");

    a_no_fire_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(phase_reg))
        else $error("state moved without a decoded word");

endmodule

### rtl/core/tked_out_queue.sv
// tked_out_queue: four-word result queue that absorbs up to two words per cycle.
// Depends on tked_pkg.
`timescale 1ns / 1ps

module tked_out_queue
    import tked_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dec_res_t res,
    output logic     space_ok,
    output logic     out_valid,
    input  logic     out_ready,
    output qword_t   out_word
);

    qword_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   head_reg, tail_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;
    logic [QPTR_W-1:0]   tail_p1;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem[head_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign tail_p1   = tail_reg + 1'b1;
    assign count_next = count_reg + QCNT_W'(res.num) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (res.num != 2'd0) begin
            mem[tail_reg] <= res.w0;
        end
        if (res.num == 2'd2) begin
            mem[tail_p1] <= res.w1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_reg + QPTR_W'(pop);
            tail_reg  <= tail_reg + QPTR_W'(res.num);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue overfilled");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res.num != 2'd0 |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("push without room");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(tail_reg - head_reg) == count_reg[QPTR_W-1:0])
        else $error("pointers disagree with count");

endmodule

### rtl/core/terminal_key_escape_decoder_unit.sv
// terminal_key_escape_decoder_unit: top level of the terminal key escape decoder.
// Depends on tked_pkg, tked_decode and tked_out_queue.
//
// Usage:
//   Slave stream s_*: one keyboard byte per word in s_tdata[7:0].
//   Master stream m_*: one key code per word in m_tdata[10:0] (plain byte
//   0-255 or extended code 1000-1106); m_tlast marks the last word caused
//   by an input byte. A byte yields zero, one or two words.
//   Flow: a byte taken from s_* sits in the input register, is decoded
//   from there and written to the result queue, where m_tvalid rises;
//   while the queue lacks room the byte waits in the input register.
//   Throughput: one byte per cycle while the receiver takes one word per
//   cycle; an ESC followed by an ordinary byte gives two words, both
//   written to the queue together. The four-word result queue sets this.
//   Receiver stall: the queue fills, the decoder holds its byte once fewer
//   than two slots are free, and s_tready drops when the input register
//   is then also full. No word is lost.
//   Reset (aresetn low, synchronous): queue emptied, decoder back to idle,
//   any part-received escape sequence discarded.
`timescale 1ns / 1ps

module terminal_key_escape_decoder_unit
    import tked_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [10:0] key_code, [15:11] zero
    output logic               m_tlast
);

    dec_res_t res;
    logic     space_ok;
    qword_t   out_word;

    tked_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .space_ok (space_ok),
        .res      (res)
    );

    tked_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {{(TDATA_W-CODE_W){1'b0}}, out_word.code};
    assign m_tlast = out_word.last;

endmodule
